### design/ir_raw_pulse_capture_defines.svh
// Assertion macros used by the checker file of the infrared pulse capture block.
`ifndef IR_RAW_PULSE_CAPTURE_DEFINES_SVH
`define IR_RAW_PULSE_CAPTURE_DEFINES_SVH

// Checked on every rising edge of clk while rst is low.
`define IRPC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("irpc: property failed");

// Checked on every rising edge of clk, reset included.
`define IRPC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("irpc: property failed");

`endif

### design/irpc_pkg.sv
// Package with the types, codes and constants of the infrared pulse capture block.
`default_nettype none

package irpc_pkg;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [15:0] GAP_LIMIT_RST   = 16'd100;
  localparam logic [7:0]  USEC_TICK_RST   = 8'd50;
  localparam logic        MARK_LEVEL_RST  = 1'b0;
  localparam logic [15:0] LEAD_MIN_RST    = 16'd3000;
  localparam logic [15:0] LEAD_MAX_RST    = 16'd12000;
  localparam logic [7:0]  MIN_ENTRIES_RST = 8'd10;

  localparam logic [15:0] TIMER_MAX  = 16'hFFFF;
  localparam logic [23:0] LEN_LIMIT  = 24'd65535;
  localparam logic [15:0] LEN_SAT    = 16'hFFFF;
  localparam int unsigned SHORT_FRAME = 2;

  typedef enum logic [2:0] {
    REG_GAP_LIMIT   = 3'd0,
    REG_USEC_TICK   = 3'd1,
    REG_MARK_LEVEL  = 3'd2,
    REG_LEAD_MIN    = 3'd3,
    REG_LEAD_MAX    = 3'd4,
    REG_MIN_ENTRIES = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REARM = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_MARK  = 4'b0010,
    PH_SPACE = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  localparam logic [1:0] PH_CODE_IDLE  = 2'd0;
  localparam logic [1:0] PH_CODE_MARK  = 2'd1;
  localparam logic [1:0] PH_CODE_SPACE = 2'd2;
  localparam logic [1:0] PH_CODE_STOP  = 2'd3;

  typedef struct packed {
    logic [15:0] gap_limit;
    logic [7:0]  usec_per_tick;
    logic        mark_level;
    logic [15:0] lead_min_us;
    logic [15:0] lead_max_us;
    logic [7:0]  min_entries;
  } cfg_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE:  code = PH_CODE_IDLE;
      PH_MARK:  code = PH_CODE_MARK;
      PH_SPACE: code = PH_CODE_SPACE;
      PH_STOP:  code = PH_CODE_STOP;
      default:  code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### design/irpc_if.sv
// Handshake channels carrying the command words and the result words.
`default_nettype none

interface irpc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       pin_level;
  logic [6:0] read_index;

  modport source (output valid, output cmd, output pin_level, output read_index,
                  input ready);
  modport sink (input valid, input cmd, input pin_level, input read_index,
                output ready);
endinterface

interface irpc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_value;
  logic        recorded;
  logic [6:0]  entry_index;
  logic [7:0]  entry_total;
  logic [1:0]  phase;
  logic        frame_ready;

  modport source (output valid, output entry_value, output recorded, output entry_index,
                  output entry_total, output phase, output frame_ready, input ready);
  modport sink (input valid, input entry_value, input recorded, input entry_index,
                input entry_total, input phase, input frame_ready, output ready);
endinterface

`default_nettype wire

### design/irpc_regs.sv
// Configuration register bank behind the APB-style port.
`default_nettype none

module irpc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [irpc_pkg::APB_AW-1:0] paddr,
  input  wire logic [irpc_pkg::APB_DW-1:0] pwdata,
  output      logic [irpc_pkg::APB_DW-1:0] prdata,
  output      logic                       pready,
  output      irpc_pkg::cfg_t             cfg
);

  logic                   wr_en;
  irpc_pkg::reg_index_t   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = irpc_pkg::reg_index_t'(paddr[irpc_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit     <= irpc_pkg::GAP_LIMIT_RST;
      cfg.usec_per_tick <= irpc_pkg::USEC_TICK_RST;
      cfg.mark_level    <= irpc_pkg::MARK_LEVEL_RST;
      cfg.lead_min_us   <= irpc_pkg::LEAD_MIN_RST;
      cfg.lead_max_us   <= irpc_pkg::LEAD_MAX_RST;
      cfg.min_entries   <= irpc_pkg::MIN_ENTRIES_RST;
    end else if (wr_en) begin
      case (reg_sel)
        irpc_pkg::REG_GAP_LIMIT:   cfg.gap_limit     <= pwdata[15:0];
        irpc_pkg::REG_USEC_TICK:   cfg.usec_per_tick <= pwdata[7:0];
        irpc_pkg::REG_MARK_LEVEL:  cfg.mark_level    <= pwdata[0];
        irpc_pkg::REG_LEAD_MIN:    cfg.lead_min_us   <= pwdata[15:0];
        irpc_pkg::REG_LEAD_MAX:    cfg.lead_max_us   <= pwdata[15:0];
        irpc_pkg::REG_MIN_ENTRIES: cfg.min_entries   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      irpc_pkg::REG_GAP_LIMIT:   prdata = irpc_pkg::APB_DW'(cfg.gap_limit);
      irpc_pkg::REG_USEC_TICK:   prdata = irpc_pkg::APB_DW'(cfg.usec_per_tick);
      irpc_pkg::REG_MARK_LEVEL:  prdata = irpc_pkg::APB_DW'(cfg.mark_level);
      irpc_pkg::REG_LEAD_MIN:    prdata = irpc_pkg::APB_DW'(cfg.lead_min_us);
      irpc_pkg::REG_LEAD_MAX:    prdata = irpc_pkg::APB_DW'(cfg.lead_max_us);
      irpc_pkg::REG_MIN_ENTRIES: prdata = irpc_pkg::APB_DW'(cfg.min_entries);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/ir_raw_pulse_capture.sv
// Top level of the infrared receiver mark and space capture block.
//
// The block takes one command word per cycle unless held off (tick with a pin sample,
// rearm, or read of a stored entry) and returns a registered result word for each, as
// entries come from a duration store with a registered read port. Each tick with no frame
// ready updates the capture phase, the tick timer and the entry count and appends at most
// one duration to the store, so words may follow each other without gaps. Entries at or
// above the current count read as zero; the store needs no clearing pass after reset.
`default_nettype none

module ir_raw_pulse_capture #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  irpc_item_if.sink                        item,
  irpc_result_if.source                    result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [irpc_pkg::APB_AW-1:0] paddr,
  input  wire logic [irpc_pkg::APB_DW-1:0] pwdata,
  output      logic [irpc_pkg::APB_DW-1:0] prdata,
  output      logic                        pready
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MW = (CW > 8) ? CW : 8;
  localparam int unsigned RW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  irpc_pkg::cfg_t   cfg;

  logic [15:0]      store_mem [STORE_DEPTH];

  logic [15:0]      timer;
  logic [15:0]      timer_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  irpc_pkg::phase_t phase;
  irpc_pkg::phase_t phase_next;
  irpc_pkg::phase_t ph_eff;
  logic             ready_flag;
  logic             ready_next;
  logic [15:0]      lead_us;
  logic [15:0]      lead_eff;

  logic             accept;
  logic [15:0]      timer_inc;
  logic [23:0]      us;
  logic [15:0]      us_sat;
  logic [15:0]      us_gap;
  logic             is_mark;
  logic             wr_en;
  logic [CW-1:0]    wr_idx;
  logic [15:0]      wr_val;
  logic             rec;
  logic [6:0]       pos;
  logic             is_read;
  logic             in_range;

  logic             o_valid;
  logic [15:0]      o_val;
  logic             o_rec;
  logic [6:0]       o_pos;
  logic [7:0]       o_total;
  logic [1:0]       o_phase;
  logic             o_ready;
  logic             o_is_read;
  logic             o_in_range;
  logic [15:0]      rd_data;

  irpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.ready = !o_valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign is_read  = irpc_pkg::cmd_t'(item.cmd) == irpc_pkg::CMD_READ;
  assign in_range = RW'(item.read_index) < RW'(count);

  always_comb begin
    timer_inc  = (timer != irpc_pkg::TIMER_MAX) ? timer + 16'd1 : timer;
    us         = 24'(cfg.usec_per_tick) * 24'(timer_inc);
    us_sat     = (us > irpc_pkg::LEN_LIMIT) ? irpc_pkg::LEN_SAT : us[15:0];
    us_gap     = (us >= irpc_pkg::LEN_LIMIT) ? 16'd0 : us[15:0];
    is_mark    = item.pin_level == cfg.mark_level;
    timer_next = timer;
    count_next = count;
    phase_next = phase;
    ready_next = ready_flag;
    ph_eff     = phase;
    wr_en      = 1'b0;
    wr_idx     = count;
    wr_val     = us_sat;
    rec        = 1'b0;
    pos        = 7'd0;
    lead_eff   = 16'd0;
    case (irpc_pkg::cmd_t'(item.cmd))
      irpc_pkg::CMD_TICK: begin
        if (!ready_flag) begin
          timer_next = timer_inc;
          ph_eff     = (count >= DEPTH_C) ? irpc_pkg::PH_STOP : phase;
          phase_next = ph_eff;
          case (ph_eff)
            irpc_pkg::PH_IDLE: begin
              if (is_mark) begin
                timer_next = 16'd0;
                if (timer_inc >= cfg.gap_limit) begin
                  wr_en      = 1'b1;
                  wr_idx     = '0;
                  wr_val     = us_gap;
                  rec        = 1'b1;
                  count_next = CW'(1);
                  phase_next = irpc_pkg::PH_MARK;
                end
              end
            end
            irpc_pkg::PH_MARK: begin
              if (!is_mark) begin
                wr_en      = 1'b1;
                rec        = 1'b1;
                pos        = 7'(count);
                count_next = count + CW'(1);
                timer_next = 16'd0;
                phase_next = irpc_pkg::PH_SPACE;
              end
            end
            irpc_pkg::PH_SPACE: begin
              if (is_mark) begin
                wr_en      = 1'b1;
                rec        = 1'b1;
                pos        = 7'(count);
                count_next = count + CW'(1);
                timer_next = 16'd0;
                phase_next = irpc_pkg::PH_MARK;
              end else if (timer_inc > cfg.gap_limit) begin
                phase_next = irpc_pkg::PH_STOP;
              end
            end
            irpc_pkg::PH_STOP: begin
              if (count <= CW'(irpc_pkg::SHORT_FRAME)) begin
                phase_next = irpc_pkg::PH_IDLE;
              end
              if (is_mark) begin
                timer_next = 16'd0;
              end
            end
            default: ;
          endcase
          lead_eff = (count_next > CW'(1)) ? lead_us : 16'd0;
          if (phase_next == irpc_pkg::PH_STOP && MW'(count_next) > MW'(cfg.min_entries)
              && lead_eff >= cfg.lead_min_us && lead_eff <= cfg.lead_max_us) begin
            ready_next = 1'b1;
          end
        end
      end
      irpc_pkg::CMD_REARM: begin
        count_next = '0;
        phase_next = irpc_pkg::PH_IDLE;
        ready_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer      <= '0;
      count      <= '0;
      phase      <= irpc_pkg::PH_IDLE;
      ready_flag <= 1'b0;
    end else if (accept) begin
      timer      <= timer_next;
      count      <= count_next;
      phase      <= phase_next;
      ready_flag <= ready_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store_mem[AW'(wr_idx)] <= wr_val;
    end
    if (accept && is_read) begin
      rd_data <= store_mem[AW'(item.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en && wr_idx == CW'(1)) begin
      lead_us <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (accept) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_val      <= rec ? wr_val : 16'd0;
      o_rec      <= rec;
      o_pos      <= is_read ? item.read_index : pos;
      o_total    <= 8'(count_next);
      o_phase    <= irpc_pkg::phase_code(phase_next);
      o_ready    <= ready_next;
      o_is_read  <= is_read;
      o_in_range <= in_range;
    end
  end

  assign result.valid       = o_valid;
  assign result.entry_value = o_is_read ? (o_in_range ? rd_data : 16'd0) : o_val;
  assign result.recorded    = o_rec;
  assign result.entry_index = o_pos;
  assign result.entry_total = o_total;
  assign result.phase       = o_phase;
  assign result.frame_ready = o_ready;

endmodule

`default_nettype wire

### design/irpc_checker.sv
// Port-level checks on the result channel of the infrared pulse capture block.
`default_nettype none

`include "ir_raw_pulse_capture_defines.svh"

module irpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_recorded,
  input wire logic [1:0] out_phase,
  input wire logic       out_frame_ready
);

  logic in_stop;
  logic in_pulse;

  assign in_stop  = out_phase == irpc_pkg::PH_CODE_STOP;
  assign in_pulse = (out_phase == irpc_pkg::PH_CODE_MARK)
                    || (out_phase == irpc_pkg::PH_CODE_SPACE);

  `IRPC_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid)
  `IRPC_ASSERT(a_ready_in_stop, out_valid && out_frame_ready |-> in_stop)
  `IRPC_ASSERT(a_record_phase, out_valid && out_recorded |-> in_pulse)
  `IRPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind ir_raw_pulse_capture irpc_checker u_irpc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_recorded    (result.recorded),
  .out_phase       (result.phase),
  .out_frame_ready (result.frame_ready)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the infrared mark and space capture block, with its own capture model.
module tb;

  localparam int unsigned CAP_DEPTH   = 128;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    irpc_pkg::cmd_t cmd;
    logic           pin;
    logic [6:0]     index;
  } cmd_word_t;

  typedef struct packed {
    logic [15:0] value;
    logic        recorded;
    logic [6:0]  index;
    logic [7:0]  total;
    logic [1:0]  phase;
    logic        frame_ready;
  } capture_status_t;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [irpc_pkg::APB_AW-1:0] paddr;
  logic [irpc_pkg::APB_DW-1:0] pwdata;
  logic [irpc_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  irpc_item_if   item_bus ();
  irpc_result_if status_bus ();

  ir_raw_pulse_capture #(.STORE_DEPTH(CAP_DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (status_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cmd_word_t       cmd_backlog[$];
  capture_status_t status_due[$];

  irpc_pkg::cfg_t cap_cfg;
  logic [15:0]    cap_timer;
  int unsigned    cap_count;
  logic [1:0]     cap_phase;
  logic           cap_ready;
  logic [15:0]    cap_store [CAP_DEPTH];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_queued = 0;
  int unsigned send_gap     = 0;
  int unsigned sink_gap     = 0;
  int unsigned hold_left    = 0;
  bit          word_offered = 1'b0;
  bit          allow_idle   = 1'b0;
  bit          hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
      end
    end
  endfunction

  function automatic logic [15:0] stored_entry(int unsigned idx);
    if (idx >= cap_count || idx >= CAP_DEPTH) return '0;
    return cap_store[idx];
  endfunction

  function automatic void append_entry(logic [15:0] v);
    if (cap_count < CAP_DEPTH) begin
      cap_store[cap_count] = v;
      cap_count++;
    end
  endfunction

  function automatic logic [15:0] clip_length(int unsigned us);
    return (us > 32'(irpc_pkg::LEN_LIMIT)) ? irpc_pkg::LEN_SAT : 16'(us);
  endfunction

  function automatic capture_status_t capture_step(cmd_word_t w);
    capture_status_t s;
    logic            is_mark;
    int unsigned     us;
    int unsigned     lead;
    s = '0;
    if (w.cmd == irpc_pkg::CMD_TICK && !cap_ready) begin
      is_mark = (w.pin == cap_cfg.mark_level);
      if (cap_timer != irpc_pkg::TIMER_MAX) cap_timer++;
      us = 32'(cap_cfg.usec_per_tick) * 32'(cap_timer);
      if (cap_count >= CAP_DEPTH) cap_phase = irpc_pkg::PH_CODE_STOP;
      case (cap_phase)
        irpc_pkg::PH_CODE_IDLE: begin
          if (is_mark) begin
            if (cap_timer < cap_cfg.gap_limit) begin
              cap_timer = '0;
            end else begin
              cap_count = 0;
              s.value = (us >= 32'(irpc_pkg::LEN_LIMIT)) ? 16'd0 : 16'(us);
              s.recorded = 1'b1;
              s.index = '0;
              append_entry(s.value);
              cap_timer = '0;
              cap_phase = irpc_pkg::PH_CODE_MARK;
            end
          end
        end
        irpc_pkg::PH_CODE_MARK: begin
          if (!is_mark) begin
            s.value = clip_length(us);
            s.recorded = 1'b1;
            s.index = 7'(cap_count);
            append_entry(s.value);
            cap_timer = '0;
            cap_phase = irpc_pkg::PH_CODE_SPACE;
          end
        end
        irpc_pkg::PH_CODE_SPACE: begin
          if (is_mark) begin
            s.value = clip_length(us);
            s.recorded = 1'b1;
            s.index = 7'(cap_count);
            append_entry(s.value);
            cap_timer = '0;
            cap_phase = irpc_pkg::PH_CODE_MARK;
          end else if (cap_timer > cap_cfg.gap_limit) begin
            cap_phase = irpc_pkg::PH_CODE_STOP;
          end
        end
        default: begin
          if (cap_count <= irpc_pkg::SHORT_FRAME) cap_phase = irpc_pkg::PH_CODE_IDLE;
          if (is_mark) cap_timer = '0;
        end
      endcase
      if (cap_phase == irpc_pkg::PH_CODE_STOP && cap_count > cap_cfg.min_entries) begin
        lead = stored_entry(1);
        if (lead >= cap_cfg.lead_min_us && lead <= cap_cfg.lead_max_us) cap_ready = 1'b1;
      end
    end else if (w.cmd == irpc_pkg::CMD_REARM) begin
      cap_count = 0;
      cap_phase = irpc_pkg::PH_CODE_IDLE;
      cap_ready = 1'b0;
    end else if (w.cmd == irpc_pkg::CMD_READ) begin
      s.value = stored_entry(w.index);
      s.index = w.index;
    end
    s.total = 8'(cap_count);
    s.phase = cap_phase;
    s.frame_ready = cap_ready;
    return s;
  endfunction

  function automatic irpc_pkg::cfg_t make_cfg(logic [15:0] gap, logic [7:0] usec, logic mark,
                                              logic [15:0] lmin, logic [15:0] lmax,
                                              logic [7:0] minent);
    irpc_pkg::cfg_t c;
    c.gap_limit = gap;
    c.usec_per_tick = usec;
    c.mark_level = mark;
    c.lead_min_us = lmin;
    c.lead_max_us = lmax;
    c.min_entries = minent;
    return c;
  endfunction

  function automatic logic [irpc_pkg::APB_DW-1:0] reg_value(irpc_pkg::cfg_t c,
                                                            irpc_pkg::reg_index_t r);
    case (r)
      irpc_pkg::REG_GAP_LIMIT:  return irpc_pkg::APB_DW'(c.gap_limit);
      irpc_pkg::REG_USEC_TICK:  return irpc_pkg::APB_DW'(c.usec_per_tick);
      irpc_pkg::REG_MARK_LEVEL: return irpc_pkg::APB_DW'(c.mark_level);
      irpc_pkg::REG_LEAD_MIN:   return irpc_pkg::APB_DW'(c.lead_min_us);
      irpc_pkg::REG_LEAD_MAX:   return irpc_pkg::APB_DW'(c.lead_max_us);
      default:                  return irpc_pkg::APB_DW'(c.min_entries);
    endcase
  endfunction

  task automatic apb_xfer(input logic write, input irpc_pkg::reg_index_t r,
                          input logic [irpc_pkg::APB_DW-1:0] wdata,
                          output logic [irpc_pkg::APB_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {r, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input irpc_pkg::cfg_t c);
    logic [irpc_pkg::APB_DW-1:0] rd;
    for (int i = 0; i <= int'(irpc_pkg::REG_MIN_ENTRIES); i++) begin
      apb_xfer(1'b1, irpc_pkg::reg_index_t'(i), reg_value(c, irpc_pkg::reg_index_t'(i)), rd);
    end
    cap_cfg = c;
    for (int i = 0; i <= int'(irpc_pkg::REG_MIN_ENTRIES); i++) begin
      apb_xfer(1'b0, irpc_pkg::reg_index_t'(i), '0, rd);
      check_field("register read-back", reg_value(c, irpc_pkg::reg_index_t'(i)), rd);
    end
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic void push_word(irpc_pkg::cmd_t c, logic pin, logic [6:0] idx);
    cmd_backlog.push_back('{cmd: c, pin: pin, index: idx});
    words_queued++;
  endfunction

  function automatic void push_ticks(logic pin, int unsigned n);
    repeat (n) push_word(irpc_pkg::CMD_TICK, pin, 7'($urandom_range(0, 127)));
  endfunction

  function automatic void push_noise(int unsigned n);
    repeat (n) begin
      push_word(irpc_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                7'($urandom_range(0, 127)));
    end
  endfunction

  function automatic void push_frame(int unsigned pairs);
    logic        mark_pin;
    int unsigned lo;
    int unsigned hi;
    int unsigned lead;
    int unsigned span;
    int unsigned top;
    mark_pin = cap_cfg.mark_level;
    span = (cap_cfg.gap_limit < 3) ? 32'(cap_cfg.gap_limit) + 1 : 3;
    lo = (32'(cap_cfg.lead_min_us) + 32'(cap_cfg.usec_per_tick) - 1) / 32'(cap_cfg.usec_per_tick);
    if (lo == 0) lo = 1;
    hi = 32'(cap_cfg.lead_max_us) / 32'(cap_cfg.usec_per_tick);
    if (lo <= hi && $urandom_range(0, 4) != 0) begin
      lead = $urandom_range(lo, (hi > lo + 4) ? lo + 4 : hi);
    end else begin
      lead = $urandom_range(1, 6);
    end
    top = (2 * pairs + 3 > 127) ? 127 : 2 * pairs + 3;
    if ($urandom_range(0, 6) != 0) push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    push_ticks(!mark_pin, 32'(cap_cfg.gap_limit) + $urandom_range(0, 2));
    push_ticks(mark_pin, lead);
    repeat (pairs) begin
      push_ticks(!mark_pin, $urandom_range(1, span));
      push_ticks(mark_pin, $urandom_range(1, 3));
      if ($urandom_range(0, 15) == 0) push_noise(1);
    end
    push_ticks(!mark_pin, 32'(cap_cfg.gap_limit) + 2 + $urandom_range(0, 2));
    repeat ($urandom_range(1, 3)) begin
      push_word(irpc_pkg::CMD_READ, 1'b0, 7'($urandom_range(0, top)));
    end
    push_ticks(1'($urandom_range(0, 1)), 1);
  endfunction

  task automatic run_frames(int unsigned target, int unsigned max_pairs);
    int unsigned start;
    start = words_queued;
    while (words_queued - start < target) begin
      push_frame($urandom_range(0, max_pairs));
      if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 4));
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      item_bus.cmd <= irpc_pkg::CMD_NOP;
      item_bus.pin_level <= 1'b0;
      item_bus.read_index <= '0;
    end else if (word_offered) begin
    end else if (send_gap > 0) begin
      item_bus.valid <= 1'b0;
      send_gap--;
    end else if (cmd_backlog.size() == 0) begin
      item_bus.valid <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 5);
      item_bus.valid <= 1'b0;
    end else begin
      item_bus.valid <= 1'b1;
      item_bus.cmd <= cmd_backlog[0].cmd;
      item_bus.pin_level <= cmd_backlog[0].pin;
      item_bus.read_index <= cmd_backlog[0].index;
      word_offered = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      status_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      status_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      status_bus.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      status_bus.ready <= 1'b0;
      sink_gap--;
    end else if (allow_idle && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 5);
      status_bus.ready <= 1'b0;
    end else begin
      status_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_word_t       w;
    capture_status_t got;
    capture_status_t want;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        w.cmd = irpc_pkg::cmd_t'(item_bus.cmd);
        w.pin = item_bus.pin_level;
        w.index = item_bus.read_index;
        status_due.push_back(capture_step(w));
        void'(cmd_backlog.pop_front());
        word_offered = 1'b0;
      end
      if (status_bus.valid && status_bus.ready) begin
        got = '{value: status_bus.entry_value, recorded: status_bus.recorded,
                index: status_bus.entry_index, total: status_bus.entry_total,
                phase: status_bus.phase, frame_ready: status_bus.frame_ready};
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result word with none outstanding", $realtime);
        end else begin
          want = status_due.pop_front();
          check_field("entry_value", want.value, got.value);
          check_field("recorded", want.recorded, got.recorded);
          check_field("entry_index", want.index, got.index);
          check_field("entry_total", want.total, got.total);
          check_field("phase", want.phase, got.phase);
          check_field("frame_ready", want.frame_ready, got.frame_ready);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (status_bus.valid && status_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ir_raw_pulse_capture test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_bus.valid = 1'b0;
    item_bus.cmd = irpc_pkg::CMD_NOP;
    item_bus.pin_level = 1'b0;
    item_bus.read_index = '0;
    status_bus.ready = 1'b0;
    cap_cfg = make_cfg(irpc_pkg::GAP_LIMIT_RST, irpc_pkg::USEC_TICK_RST,
                       irpc_pkg::MARK_LEVEL_RST, irpc_pkg::LEAD_MIN_RST,
                       irpc_pkg::LEAD_MAX_RST, irpc_pkg::MIN_ENTRIES_RST);
    cap_timer = '0;
    cap_count = 0;
    cap_phase = irpc_pkg::PH_CODE_IDLE;
    cap_ready = 1'b0;
    foreach (cap_store[i]) cap_store[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_word(irpc_pkg::CMD_NOP, 1'b1, 7'd127);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd0);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd127);
    push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    push_word(irpc_pkg::CMD_TICK, 1'b0, 7'd85);
    push_word(irpc_pkg::CMD_TICK, 1'b1, 7'd42);
    push_word(irpc_pkg::CMD_READ, 1'b1, 7'd85);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd42);
    wait_idle();

    // A two-entry frame is accepted when the entry floor is zero; the tick after is frozen.
    configure(make_cfg(16'd2, 8'd255, 1'b1, 16'd0, 16'hFFFF, 8'd0));
    push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    push_ticks(1'b0, 3);
    push_ticks(1'b1, 2);
    push_ticks(1'b0, 4);
    push_ticks(1'b1, 1);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd1);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd2);
    push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    wait_idle();

    allow_idle = 1'b1;
    configure(make_cfg(16'd4, 8'd50, 1'b0, 16'd100, 16'd300, 8'd4));
    run_frames(40, 6);
    wait_idle();

    allow_idle = ($urandom_range(0, 3) != 0);
    configure(make_cfg(16'd1, 8'd1, 1'b1, 16'd0, 16'hFFFF, 8'd0));
    run_frames(30, 5);
    wait_idle();

    allow_idle = 1'b1;
    configure(make_cfg(16'd6, 8'd255, 1'b0, 16'hFFFF, 16'd0, 8'd2));
    run_frames(30, 5);
    wait_idle();

    // The store fills up and forces the stop phase; the receiver first holds off the results.
    configure(make_cfg(16'd3, 8'd200, 1'b1, 16'd400, 16'd1000, 8'd127));
    hold_request = 1'b1;
    push_frame(66);
    push_noise(10);
    wait_idle();

    allow_idle = ($urandom_range(0, 3) != 0);
    configure(make_cfg(16'hFFFF, 8'd100, 1'b0, 16'd0, 16'd0, 8'd128));
    push_noise(30);
    wait_idle();

    // A long idle gap is stored as zero and a long mark saturates.
    allow_idle = 1'b1;
    configure(make_cfg(16'd5, 8'd255, 1'b1, 16'd0, 16'hFFFF, 8'd3));
    push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    push_ticks(1'b0, 258);
    push_ticks(1'b1, 258);
    push_ticks(1'b0, 2);
    push_ticks(1'b1, 2);
    push_ticks(1'b0, 8);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd0);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd1);
    push_word(irpc_pkg::CMD_READ, 1'b0, 7'd3);
    push_ticks(1'b1, 1);
    push_word(irpc_pkg::CMD_REARM, 1'b0, 7'd0);
    wait_idle();

    allow_idle = 1'b0;
    configure(make_cfg(16'd2, 8'd64, 1'b0, 16'd128, 16'd640, 8'd6));
    run_frames(60, 8);
    wait_idle();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && status_due.size() == 0) begin
      $display("ir_raw_pulse_capture test passed");
    end else begin
      $display("ir_raw_pulse_capture test failed");
    end
    $finish;
  end

endmodule
